FILE: hdl/msr_pkg.sv
// Shared types, constants and a saturation helper for the mass-spring rope step block.
// No dependencies; imported by the top level, the divider and the checker.
package msr_pkg;

  localparam int NODES_DEF = 32;
  localparam int FRAC_BITS = 16;

  typedef logic signed [31:0] q_t;

  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = 32'sh8000_0000;
  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  localparam int Q_ONE_I = 1 << FRAC_BITS;
  localparam q_t K_REL    = 32'((5 * Q_ONE_I + 50) / 100);
  localparam q_t K_AIR    = 32'((5 * Q_ONE_I + 500) / 1000);
  localparam q_t K_KEEP   = 32'(Q_ONE_I - (5 * Q_ONE_I + 50000) / 100000);

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_STEP    = 1'b1;
  localparam logic MODE_EULER = 1'b0;

  localparam logic [2:0] REG_NODE_COUNT = 3'd0;
  localparam logic [2:0] REG_STIFFNESS  = 3'd1;
  localparam logic [2:0] REG_NODE_MASS  = 3'd2;
  localparam logic [2:0] REG_TIME_STEP  = 3'd3;
  localparam logic [2:0] REG_GRAVITY_X  = 3'd4;
  localparam logic [2:0] REG_GRAVITY_Y  = 3'd5;
  localparam logic [2:0] REG_REST_LEN   = 3'd6;
  localparam logic [2:0] REG_MODE       = 3'd7;

  typedef struct packed {
    logic       opcode;
    logic [4:0] node_index;
    q_t         load_x;
    q_t         load_y;
    logic       pinned_flag;
  } in_item_t;

  typedef struct packed {
    logic [4:0] out_index;
    q_t         out_x;
    q_t         out_y;
    logic       last_node;
  } out_item_t;

  typedef struct packed {
    q_t px;
    q_t py;
    q_t vx;
    q_t vy;
    q_t qx;
    q_t qy;
  } node_t;

  function automatic q_t sat32(input logic signed [65:0] v);
    if (v > SAT_HI) begin
      return Q_MAX;
    end else if (v < SAT_LO) begin
      return Q_MIN;
    end
    return $signed(v[31:0]);
  endfunction

endpackage

FILE: hdl/mass_spring_rope_step.sv
// Mass-spring rope step: node state in one RAM, walked by a sequencer with shared units.
// Load request: written straight into the RAM. Step request: each node goes through the shared
// square root and dividers, with extra work in Euler mode, then each node is reported;
// no new request is taken until the last node is delivered.
// Reset (rst_n low, synchronous) restores register defaults and clears pinned flags.
// Depends on msr_pkg, msr_ram, msr_div and msr_sqrt.
module mass_spring_rope_step #(
  parameter int NODES = msr_pkg::NODES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  msr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output msr_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import msr_pkg::*;

  localparam int AW   = $clog2(NODES);
  localparam int NLIM = (NODES < 32) ? NODES : 32;

  typedef enum logic [40:0] {
    ST_IDLE  = 41'd1 << 0,  ST_RDA   = 41'd1 << 1,  ST_CAPA  = 41'd1 << 2,
    ST_RDB   = 41'd1 << 3,  ST_CAPB  = 41'd1 << 4,  ST_DIFF  = 41'd1 << 5,
    ST_SQ    = 41'd1 << 6,  ST_SQS   = 41'd1 << 7,  ST_ROOT  = 41'd1 << 8,
    ST_SMUL  = 41'd1 << 9,  ST_SCAP  = 41'd1 << 10, ST_FMUL  = 41'd1 << 11,
    ST_FDIV  = 41'd1 << 12, ST_FWAIT = 41'd1 << 13, ST_REL   = 41'd1 << 14,
    ST_RMUL  = 41'd1 << 15, ST_DOT   = 41'd1 << 16, ST_DMUL  = 41'd1 << 17,
    ST_DCAP  = 41'd1 << 18, ST_GMUL  = 41'd1 << 19, ST_GDIV  = 41'd1 << 20,
    ST_GWAIT = 41'd1 << 21, ST_AIRA  = 41'd1 << 22, ST_AIRB  = 41'd1 << 23,
    ST_AIRC  = 41'd1 << 24, ST_ADV   = 41'd1 << 25, ST_AWAIT = 41'd1 << 26,
    ST_EV1   = 41'd1 << 27, ST_EV2   = 41'd1 << 28, ST_EP1   = 41'd1 << 29,
    ST_EP2   = 41'd1 << 30, ST_VM1   = 41'd1 << 31, ST_VM2   = 41'd1 << 32,
    ST_VM3   = 41'd1 << 33, ST_VM4   = 41'd1 << 34, ST_VM5   = 41'd1 << 35,
    ST_WR    = 41'd1 << 36, ST_NEXT  = 41'd1 << 37, ST_ORD   = 41'd1 << 38,
    ST_OCAP  = 41'd1 << 39, ST_OWAIT = 41'd1 << 40
  } state_t;

  state_t state_r, state_nxt;

  logic [5:0]  nc_r;
  logic [30:0] stiff_r, mass_r, rest_r;
  logic [16:0] ts_r;
  q_t          gx_r, gy_r;
  logic        mode_r;

  logic [NODES-1:0] pin_r;
  logic [5:0]       cnt_r, n_r, n_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r;

  node_t a_r, b_r;
  q_t    fa_x_r, fa_y_r, fb_x_r, fb_y_r;
  q_t    dx_r, dy_r, s_r, t_x_r, t_y_r, u_x_r, u_y_r;
  logic [31:0] len_r;

  logic signed [63:0] mul_x_r, mul_y_r;
  q_t mx_a, mx_b, my_a, my_b;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr, a_addr;
  node_t         ram_wdata, ram_rdata;

  logic               div_start, div_done_x, div_done_y, div_done;
  logic signed [63:0] dv_x, dv_y;
  logic [31:0]        dv_d;
  q_t                 qt_x, qt_y;

  logic        sq_start, sq_done;
  logic [31:0] sq_root;

  logic in_acc, euler, more, more2, is_last;
  q_t   ts_q, stiff_q, lenrest;

  function automatic q_t qs(input logic signed [63:0] p);
    return sat32(66'(p >>> FRAC_BITS));
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = state_r != ST_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign div_done  = div_done_x && div_done_y;

  assign euler   = mode_r == MODE_EULER;
  assign a_addr  = AW'(cnt_r);
  assign more    = (7'(cnt_r) + 7'd1) < 7'(n_r);
  assign more2   = (7'(cnt_r) + 7'd2) < 7'(n_r);
  assign is_last = (cnt_r + 6'd1) == n_r;
  assign n_nxt   = (int'(nc_r) > NLIM) ? 6'(NLIM) : nc_r;
  assign ts_q    = $signed({15'b0, ts_r});
  assign stiff_q = $signed({1'b0, stiff_r});
  assign lenrest = sat32($signed({34'b0, len_r}) - $signed({35'b0, rest_r}));

  msr_ram #(.W($bits(node_t)), .DEPTH(NODES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  msr_div u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dv_x), .divisor(dv_d),
    .done(div_done_x), .quot(qt_x)
  );

  msr_div u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dv_y), .divisor(dv_d),
    .done(div_done_y), .quot(qt_y)
  );

  msr_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start),
    .op($unsigned(mul_x_r) + $unsigned(mul_y_r)), .done(sq_done), .root(sq_root)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = a_addr;
    ram_wdata = a_r;
    if (state_r == ST_WR) begin
      ram_we = 1'b1;
    end else if (in_acc && in_data.opcode == OP_LOAD && int'(in_data.node_index) < NODES) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(in_data.node_index);
      ram_wdata = '{px: in_data.load_x, py: in_data.load_y, vx: '0, vy: '0,
                    qx: in_data.load_x, qy: in_data.load_y};
    end
    ram_raddr = (state_r == ST_RDB) ? AW'(cnt_r + 6'd1) : a_addr;
  end

  always_comb begin
    div_start = 1'b0;
    dv_x      = mul_x_r;
    dv_y      = mul_y_r;
    dv_d      = len_r;
    case (state_r)
      ST_FDIV, ST_GDIV: begin
        div_start = 1'b1;
      end
      ST_ADV: begin
        div_start = !pin_r[a_addr];
        dv_x      = 64'(sat32(66'(fa_x_r) + 66'(gx_r))) <<< FRAC_BITS;
        dv_y      = 64'(sat32(66'(fa_y_r) + 66'(gy_r))) <<< FRAC_BITS;
        dv_d      = {1'b0, mass_r};
      end
      default: begin
      end
    endcase
  end

  assign sq_start = state_r == ST_SQS;

  always_comb begin
    mx_a = '0;
    mx_b = '0;
    my_a = '0;
    my_b = '0;
    case (state_r)
      ST_SQ: begin
        mx_a = dx_r; mx_b = dx_r; my_a = dy_r; my_b = dy_r;
      end
      ST_SMUL: begin
        mx_a = stiff_q; mx_b = lenrest;
      end
      ST_FMUL, ST_GMUL: begin
        mx_a = s_r; mx_b = dx_r; my_a = s_r; my_b = dy_r;
      end
      ST_RMUL: begin
        mx_a = t_x_r; mx_b = dx_r; my_a = t_y_r; my_b = dy_r;
      end
      ST_DMUL: begin
        mx_a = K_REL; mx_b = t_x_r;
      end
      ST_AIRA: begin
        mx_a = K_AIR; mx_b = a_r.vx; my_a = K_AIR; my_b = a_r.vy;
      end
      ST_AIRB: begin
        mx_a = K_AIR; mx_b = b_r.vx; my_a = K_AIR; my_b = b_r.vy;
      end
      ST_EV1, ST_VM1, ST_VM3: begin
        mx_a = t_x_r; mx_b = ts_q; my_a = t_y_r; my_b = ts_q;
      end
      ST_EP1: begin
        mx_a = a_r.vx; mx_b = ts_q; my_a = a_r.vy; my_b = ts_q;
      end
      ST_VM4: begin
        mx_a = K_KEEP; mx_b = u_x_r; my_a = K_KEEP; my_b = u_y_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_x_r <= 64'(mx_a) * 64'(mx_b);
    mul_y_r <= 64'(my_a) * 64'(my_b);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.opcode == OP_STEP && n_nxt != '0) begin
          state_nxt = ST_RDA;
        end
      end
      ST_RDA:   state_nxt = ST_CAPA;
      ST_CAPA:  state_nxt = more ? ST_RDB : ST_ADV;
      ST_RDB:   state_nxt = ST_CAPB;
      ST_CAPB:  state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_SQ;
      ST_SQ:    state_nxt = ST_SQS;
      ST_SQS:   state_nxt = ST_ROOT;
      ST_ROOT:  state_nxt = sq_done ? ST_SMUL : ST_ROOT;
      ST_SMUL: begin
        if (len_r != '0) begin
          state_nxt = ST_SCAP;
        end else begin
          state_nxt = euler ? ST_AIRA : ST_ADV;
        end
      end
      ST_SCAP:  state_nxt = ST_FMUL;
      ST_FMUL:  state_nxt = ST_FDIV;
      ST_FDIV:  state_nxt = ST_FWAIT;
      ST_FWAIT: begin
        if (div_done) begin
          state_nxt = euler ? ST_REL : ST_ADV;
        end
      end
      ST_REL:   state_nxt = ST_RMUL;
      ST_RMUL:  state_nxt = ST_DOT;
      ST_DOT:   state_nxt = ST_DMUL;
      ST_DMUL:  state_nxt = ST_DCAP;
      ST_DCAP:  state_nxt = ST_GMUL;
      ST_GMUL:  state_nxt = ST_GDIV;
      ST_GDIV:  state_nxt = ST_GWAIT;
      ST_GWAIT: state_nxt = div_done ? ST_AIRA : ST_GWAIT;
      ST_AIRA:  state_nxt = ST_AIRB;
      ST_AIRB:  state_nxt = ST_AIRC;
      ST_AIRC:  state_nxt = ST_ADV;
      ST_ADV:   state_nxt = pin_r[a_addr] ? ST_NEXT : ST_AWAIT;
      ST_AWAIT: begin
        if (div_done) begin
          state_nxt = euler ? ST_EV1 : ST_VM1;
        end
      end
      ST_EV1:   state_nxt = ST_EV2;
      ST_EV2:   state_nxt = ST_EP1;
      ST_EP1:   state_nxt = ST_EP2;
      ST_EP2:   state_nxt = ST_WR;
      ST_VM1:   state_nxt = ST_VM2;
      ST_VM2:   state_nxt = ST_VM3;
      ST_VM3:   state_nxt = ST_VM4;
      ST_VM4:   state_nxt = ST_VM5;
      ST_VM5:   state_nxt = ST_WR;
      ST_WR:    state_nxt = ST_NEXT;
      ST_NEXT: begin
        if (more) begin
          state_nxt = more2 ? ST_RDB : ST_ADV;
        end else begin
          state_nxt = ST_ORD;
        end
      end
      ST_ORD:   state_nxt = ST_OCAP;
      ST_OCAP:  state_nxt = ST_OWAIT;
      ST_OWAIT: begin
        if (!out_stall) begin
          state_nxt = is_last ? ST_IDLE : ST_ORD;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
      pin_r       <= '0;
      nc_r        <= 6'd32;
      stiff_r     <= 31'd65536;
      mass_r      <= 31'd65536;
      ts_r        <= 17'd655;
      gx_r        <= '0;
      gy_r        <= -32'sd65536;
      rest_r      <= 31'd65536;
      mode_r      <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NODE_COUNT: nc_r    <= cfg_data[5:0];
          REG_STIFFNESS:  stiff_r <= cfg_data[30:0];
          REG_NODE_MASS:  mass_r  <= cfg_data[30:0];
          REG_TIME_STEP:  ts_r    <= cfg_data[16:0];
          REG_GRAVITY_X:  gx_r    <= $signed(cfg_data);
          REG_GRAVITY_Y:  gy_r    <= $signed(cfg_data);
          REG_REST_LEN:   rest_r  <= cfg_data[30:0];
          REG_MODE:       mode_r  <= cfg_data[0];
          default: begin
          end
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && in_data.opcode == OP_STEP) begin
            n_r   <= n_nxt;
            cnt_r <= '0;
          end else if (in_acc && int'(in_data.node_index) < NODES) begin
            pin_r[AW'(in_data.node_index)] <= in_data.pinned_flag;
          end
        end
        ST_NEXT: begin
          cnt_r <= more ? cnt_r + 6'd1 : '0;
        end
        ST_OCAP: begin
          out_valid_r <= 1'b1;
        end
        ST_OWAIT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            cnt_r       <= cnt_r + 6'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_CAPA: begin
        a_r    <= ram_rdata;
        fa_x_r <= '0;
        fa_y_r <= '0;
      end
      ST_CAPB: begin
        b_r    <= ram_rdata;
        fb_x_r <= '0;
        fb_y_r <= '0;
      end
      ST_DIFF: begin
        dx_r <= sat32(66'(b_r.px) - 66'(a_r.px));
        dy_r <= sat32(66'(b_r.py) - 66'(a_r.py));
      end
      ST_ROOT: begin
        if (sq_done) begin
          len_r <= sq_root;
        end
      end
      ST_SCAP, ST_DCAP: begin
        s_r <= qs(mul_x_r);
      end
      ST_FWAIT, ST_GWAIT: begin
        if (div_done) begin
          fa_x_r <= sat32(66'(fa_x_r) + 66'(qt_x));
          fa_y_r <= sat32(66'(fa_y_r) + 66'(qt_y));
          fb_x_r <= sat32(66'(fb_x_r) - 66'(qt_x));
          fb_y_r <= sat32(66'(fb_y_r) - 66'(qt_y));
        end
      end
      ST_REL: begin
        t_x_r <= sat32(66'(b_r.vx) - 66'(a_r.vx));
        t_y_r <= sat32(66'(b_r.vy) - 66'(a_r.vy));
      end
      ST_DOT: begin
        t_x_r <= sat32(66'(qs(mul_x_r)) + 66'(qs(mul_y_r)));
      end
      ST_AIRB: begin
        fa_x_r <= sat32(66'(fa_x_r) - 66'(qs(mul_x_r)));
        fa_y_r <= sat32(66'(fa_y_r) - 66'(qs(mul_y_r)));
      end
      ST_AIRC: begin
        fb_x_r <= sat32(66'(fb_x_r) - 66'(qs(mul_x_r)));
        fb_y_r <= sat32(66'(fb_y_r) - 66'(qs(mul_y_r)));
      end
      ST_AWAIT: begin
        if (div_done) begin
          t_x_r <= qt_x;
          t_y_r <= qt_y;
        end
      end
      ST_EV2: begin
        a_r.vx <= sat32(66'(a_r.vx) + 66'(qs(mul_x_r)));
        a_r.vy <= sat32(66'(a_r.vy) + 66'(qs(mul_y_r)));
      end
      ST_EP2: begin
        a_r.px <= sat32(66'(a_r.px) + 66'(qs(mul_x_r)));
        a_r.py <= sat32(66'(a_r.py) + 66'(qs(mul_y_r)));
      end
      ST_VM1: begin
        u_x_r <= sat32(66'(a_r.px) - 66'(a_r.qx));
        u_y_r <= sat32(66'(a_r.py) - 66'(a_r.qy));
      end
      ST_VM2, ST_VM4: begin
        t_x_r <= qs(mul_x_r);
        t_y_r <= qs(mul_y_r);
      end
      ST_VM5: begin
        a_r.px <= sat32(66'(a_r.px) + 66'(qs(mul_x_r)) + 66'(t_x_r));
        a_r.py <= sat32(66'(a_r.py) + 66'(qs(mul_y_r)) + 66'(t_y_r));
        a_r.qx <= a_r.px;
        a_r.qy <= a_r.py;
      end
      ST_NEXT: begin
        if (more) begin
          a_r    <= b_r;
          fa_x_r <= fb_x_r;
          fa_y_r <= fb_y_r;
        end
      end
      ST_OCAP: begin
        out_data_r <= '{out_index: cnt_r[4:0], out_x: ram_rdata.px, out_y: ram_rdata.py,
                        last_node: is_last};
      end
      default: begin
      end
    endcase
  end
endmodule

FILE: hdl/msr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msr_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/msr_div.sv
// Iterative signed-by-unsigned divider, two quotient bits per cycle, saturated 32-bit result.
// Depends on msr_pkg.
module msr_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic [31:0]        divisor,
  output logic               done,
  output msr_pkg::q_t        quot
);
  import msr_pkg::*;

  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [63:0] q_r;
  logic [31:0] rem_r, d_r;
  logic        neg_r, pos_r, zero_r;
  logic [32:0] r1, r2;
  logic [63:0] q1, q2;

  always_comb begin
    r1 = {rem_r, q_r[63]};
    q1 = {q_r[62:0], 1'b0};
    if (r1 >= {1'b0, d_r}) begin
      r1    = r1 - {1'b0, d_r};
      q1[0] = 1'b1;
    end
    r2 = {r1[31:0], q1[63]};
    q2 = {q1[62:0], 1'b0};
    if (r2 >= {1'b0, d_r}) begin
      r2    = r2 - {1'b0, d_r};
      q2[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r    <= (dividend < 0) ? 64'(-dividend) : 64'(dividend);
      rem_r  <= '0;
      d_r    <= divisor;
      neg_r  <= dividend < 0;
      pos_r  <= dividend > 0;
      zero_r <= divisor == '0;
    end else if (busy_r) begin
      q_r   <= q2;
      rem_r <= r2[31:0];
    end
  end

  always_comb begin
    if (zero_r) begin
      quot = pos_r ? Q_MAX : (neg_r ? Q_MIN : '0);
    end else begin
      quot = sat32(neg_r ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r}));
    end
  end

  assign done = done_r;
endmodule

FILE: hdl/msr_sqrt.sv
// Iterative floor square root of a 64-bit value, one root bit per cycle.
// No dependencies.
module msr_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] op,
  output logic        done,
  output logic [31:0] root
);
  logic        busy_r, done_r;
  logic [63:0] v_r, r_r, bit_r, trial;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= op;
      r_r   <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];
endmodule

FILE: hdl/msr_chk.sv
// Port-level checker for the mass-spring rope step block, bound to the top level.
// Depends on msr_pkg and mass_spring_rope_step.
module msr_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input msr_pkg::out_item_t out_data
);
  import msr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken while results pending");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last_node |=> !out_valid)
    else $error("result after last node");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind mass_spring_rope_step msr_chk u_msr_chk (.*);
